FILE: rtl/core/ase_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Ascending sort engine package
// Shared sizes and the command/status bundles between controller and datapath.
// ============================================================================
package ase_pkg;

   localparam int DEPTH = 64;
   localparam int WIDTH = 32;
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef struct packed {
      logic load;
      logic sort;
      logic phase;
      logic shift;
      logic finish;
   } ase_cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
   } ase_sts_type;

endpackage

FILE: rtl/core/ase_req_if.sv
`timescale 1ns / 1ps
// ============================================================================
// Request channel
// Carries one unsorted element and the end-of-set marker per transaction.
// ============================================================================
interface ase_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [ase_pkg::WIDTH-1:0] value;
   logic                             last_in;

   modport source (output valid, value, last_in, input ready);
   modport sink (input valid, value, last_in, output ready);
endinterface

FILE: rtl/core/ase_rsp_if.sv
`timescale 1ns / 1ps
// ============================================================================
// Response channel
// Carries one sorted element with its last and overflow flags per transaction.
// ============================================================================
interface ase_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [ase_pkg::WIDTH-1:0] sorted_value;
   logic                             last_out;
   logic                             overflow;

   modport source (output valid, sorted_value, last_out, overflow, input ready);
   modport sink (input valid, sorted_value, last_out, overflow, output ready);
endinterface

FILE: rtl/core/ase_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// Ascending sort engine datapath
// Row of element cells with load, odd-even compare-and-swap and shift-out.
// ============================================================================
module ase_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  ase_pkg::ase_cmd_type             cmd,
   output ase_pkg::ase_sts_type             sts,
   input  logic signed [ase_pkg::WIDTH-1:0] value,
   output logic signed [ase_pkg::WIDTH-1:0] head_value,
   output logic                             head_last,
   output logic                             dropped
);

   logic signed [ase_pkg::WIDTH-1:0] cell_ff [ase_pkg::DEPTH];
   logic signed [ase_pkg::WIDTH-1:0] cell_in [ase_pkg::DEPTH];
   logic [ase_pkg::DEPTH-2:0]        swap;
   logic [ase_pkg::CNT_W-1:0]        count_ff;
   logic [ase_pkg::CNT_W-1:0]        count_in;
   logic                             dropped_ff;
   logic                             dropped_in;
   logic                             full;

   assign full = (count_ff == ase_pkg::CNT_W'(ase_pkg::DEPTH));

   // A pair swaps only when it belongs to the current phase, both cells hold
   // elements of the set, and the lower cell is strictly greater.
   always_comb begin
      for (int j = 0; j < ase_pkg::DEPTH - 1; j++) begin
         swap[j] = cmd.sort && (j[0] == cmd.phase)
                   && (ase_pkg::CNT_W'(j + 1) < count_ff)
                   && (cell_ff[j] > cell_ff[j + 1]);
      end
   end

   always_comb begin
      for (int i = 0; i < ase_pkg::DEPTH; i++) begin
         cell_in[i] = cell_ff[i];
         if (cmd.shift) begin
            if (i < ase_pkg::DEPTH - 1) begin
               cell_in[i] = cell_ff[i + 1];
            end
         end else if (cmd.sort) begin
            if (i < ase_pkg::DEPTH - 1 && swap[i]) begin
               cell_in[i] = cell_ff[i + 1];
            end else if (i > 0 && swap[i - 1]) begin
               cell_in[i] = cell_ff[i - 1];
            end
         end else if (cmd.load && !full && count_ff == ase_pkg::CNT_W'(i)) begin
            cell_in[i] = value;
         end
      end
   end

   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (cmd.load) begin
         if (full) begin
            dropped_in = 1'b1;
         end else begin
            count_in = count_ff + ase_pkg::CNT_W'(1);
         end
      end else if (cmd.shift) begin
         count_in = count_ff - ase_pkg::CNT_W'(1);
      end
      if (cmd.finish) begin
         dropped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   assign sts.count  = count_ff;
   assign head_value = cell_ff[0];
   assign head_last  = (count_ff == ase_pkg::CNT_W'(1));
   assign dropped    = dropped_ff;

endmodule

FILE: rtl/core/ase_controller.sv
`timescale 1ns / 1ps
// ============================================================================
// Ascending sort engine controller
// Sequences the load, sort pass and emit phases of one set.
// ============================================================================
module ase_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last_in,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ase_pkg::ase_cmd_type cmd,
   input  ase_pkg::ase_sts_type sts
);

   typedef enum logic [2:0] {
      LOAD = 3'b001,
      SORT = 3'b010,
      EMIT = 3'b100
   } state_type;

   state_type                 state_ff;
   state_type                 state_in;
   logic [ase_pkg::CNT_W-1:0] pass_ff;
   logic [ase_pkg::CNT_W-1:0] pass_in;
   logic                      req_fire;
   logic                      rsp_fire;

   assign req_ready = (state_ff == LOAD);
   assign rsp_valid = (state_ff == EMIT);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   always_comb begin
      state_in   = state_ff;
      pass_in    = pass_ff;
      cmd        = '0;
      cmd.phase  = pass_ff[0];
      case (state_ff)
         LOAD: begin
            cmd.load = req_fire;
            pass_in  = '0;
            if (req_fire && req_last_in) begin
               state_in = SORT;
            end
         end
         SORT: begin
            // A set of n elements is fully ordered after n alternating passes.
            cmd.sort = 1'b1;
            pass_in  = pass_ff + ase_pkg::CNT_W'(1);
            if (pass_in == sts.count) begin
               state_in = EMIT;
            end
         end
         EMIT: begin
            cmd.shift = rsp_fire;
            if (rsp_fire && sts.count == ase_pkg::CNT_W'(1)) begin
               cmd.finish = 1'b1;
               state_in   = LOAD;
            end
         end
         default: begin
            state_in = LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LOAD;
         pass_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
      end
   end

endmodule

FILE: rtl/core/ascending_sort_engine_core.sv
`timescale 1ns / 1ps
// Loading accepts one element per cycle; elements stream in back to back until last_in.
// Sorting then runs n odd-even passes of the cell row for a set of n stored elements,
// one pass per cycle, after which the n results leave at one per cycle under ready.
// Reset clears the controller, the element count and the dropped flag; cells are not reset.
// ============================================================================
// Ascending sort engine core
// Collects a set of signed elements, sorts them stably and streams them out.
// ============================================================================
module ascending_sort_engine_core (
   input  logic      clock,
   input  logic      reset,
   ase_req_if.sink   req_chan,
   ase_rsp_if.source rsp_chan
);

   ase_pkg::ase_cmd_type cmd;
   ase_pkg::ase_sts_type sts;

   ase_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_last_in (req_chan.last_in),
      .req_ready   (req_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .cmd         (cmd),
      .sts         (sts)
   );

   ase_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .value      (req_chan.value),
      .head_value (rsp_chan.sorted_value),
      .head_last  (rsp_chan.last_out),
      .dropped    (rsp_chan.overflow)
   );

endmodule
